// ----- src/efsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsa_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// earliest-free server assignment block.
// ----------------------------------------------------------------------------
package efsa_pkg;

  // default number of servers held in the time store
  localparam int SERVER_MAX_DEF = 16;

  // fixed field widths
  localparam int SVC_W  = 16;  // service time
  localparam int NUM_W  = 5;   // server number / server count
  localparam int TIME_W = 32;  // free-at time

  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam logic [NUM_W-1:0]  COUNT_RST  = NUM_W'(1);

  // controller -> datapath commands
  typedef struct packed {
    logic start;     // job accepted: latch it, clear times on a new case
    logic issue;     // read the next server time
    logic update;    // write back the picked server, work out the result
    logic out_load;  // move the result into the output register
  } efsa_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_issue;  // current read address is the last active server
    logic out_free;    // output register can take a result
  } efsa_sts_t;

endpackage

// ----- src/efsa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsa_job_if / efsa_res_if
// Valid/ready channels for jobs in and assignment results out.
// ----------------------------------------------------------------------------
interface efsa_job_if import efsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SVC_W-1:0] service_time;
  logic             new_case;

  modport source (output valid, output service_time, output new_case, input ready);
  modport sink   (input valid, input service_time, input new_case, output ready);
endinterface

interface efsa_res_if import efsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] assigned_server;
  logic [NUM_W-1:0] next_server;
  logic             time_saturated;

  modport source (output valid, output assigned_server, output next_server,
                  output time_saturated, input ready);
  modport sink   (input valid, input assigned_server, input next_server,
                  input time_saturated, output ready);
endinterface

// ----- src/earliest_free_server_assign.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_server_assign
// Assigns each job to the server that is free earliest and tracks the
// per-server free-at times.
// ----------------------------------------------------------------------------
// Usage:
//   job    : valid/ready sink, one transaction per job (service_time,
//            new_case). new_case clears all server times before placement.
//   result : valid/ready source, one transaction per job (assigned_server,
//            next_server, time_saturated), in job order.
//   cfg_we / cfg_wdata : writes server_count (1..SERVER_MAX, 0 acts as 1),
//            only while no job is in flight.
// Timing: one job at a time. For N active servers the time memory is read
//   once per server, then the scan drains, the picked server is updated and
//   the result is loaded into the output register; the next job is accepted
//   the cycle after the load. The single memory read port makes the scan
//   read one server time at a time.
// Reset: all server times read as zero, server_count is 1, no result valid.
// Stall: the result register holds while ready is low; a finished job waits
//   in the load step and no new job is taken until it moves.
// ----------------------------------------------------------------------------
module earliest_free_server_assign import efsa_pkg::*; #(
  parameter int SERVER_MAX = SERVER_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata,
  efsa_job_if.sink         job,
  efsa_res_if.source       result
);

  efsa_cmd_t cmd;
  efsa_sts_t sts;

  efsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job.valid),
    .job_ready (job.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  efsa_dp #(
    .SERVER_MAX (SERVER_MAX)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .service_time    (job.service_time),
    .new_case        (job.new_case),
    .cmd             (cmd),
    .sts             (sts),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .assigned_server (result.assigned_server),
    .next_server     (result.next_server),
    .time_saturated  (result.time_saturated)
  );

  // once a job is taken the block is busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !job.ready)
    else $error("job ready right after acceptance");

  // a result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending transaction");

  // memory reads never overlap job acceptance
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !job.ready)
    else $error("scan read while accepting jobs");

  // an update is followed by a load or a wait on the output
  a_update_next: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (cmd.out_load || !sts.out_free))
    else $error("result neither loaded nor stalled after update");

endmodule

// ----- src/efsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsa_ctrl
// Sequencer: accept a job, scan the active server times, write back the
// picked server, then hand the result to the output register.
// ----------------------------------------------------------------------------
module efsa_ctrl import efsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  efsa_sts_t sts,
  output efsa_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign job_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read data is folded into the running minimum here
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/efsa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsa_dp
// Datapath: server time memory with per-entry valid bits, scan comparator
// tracking the earliest and second earliest server, saturating update and
// the output register.
// ----------------------------------------------------------------------------
module efsa_dp import efsa_pkg::*; #(
  parameter int SERVER_MAX = SERVER_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata,
  input  logic [SVC_W-1:0] service_time,
  input  logic             new_case,
  input  efsa_cmd_t        cmd,
  output efsa_sts_t        sts,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [NUM_W-1:0] assigned_server,
  output logic [NUM_W-1:0] next_server,
  output logic             time_saturated
);

  localparam int IDX_W = (SERVER_MAX > 1) ? $clog2(SERVER_MAX) : 1;

  // configuration
  logic [NUM_W-1:0] server_count;

  // job and scan control
  logic [SVC_W-1:0]  svc;
  logic [IDX_W-1:0]  n_last;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_ok;
  logic              rd_vld;
  logic [TIME_W-1:0] rd_data;

  // time store
  logic [TIME_W-1:0]     mem [SERVER_MAX];
  logic [SERVER_MAX-1:0] vld;

  // scan results
  logic [TIME_W-1:0] best;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] second;
  logic [IDX_W-1:0]  second_idx;
  logic              has_second;

  // update
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] t_new;
  logic [IDX_W-1:0]  nxt_idx;
  logic [TIME_W-1:0] v;

  // pending result
  logic [NUM_W-1:0] res_assigned;
  logic [NUM_W-1:0] res_next;
  logic             res_sat;

  // active server count clamped to 1..SERVER_MAX, as a last index
  function automatic logic [IDX_W-1:0] last_index(input logic [NUM_W-1:0] cnt);
    int c;
    c = int'(cnt);
    if (c < 1) c = 1;
    if (c > SERVER_MAX) c = SERVER_MAX;
    return IDX_W'(c - 1);
  endfunction

  // server_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= COUNT_RST;
    end else if (cfg_we) begin
      server_count <= cfg_wdata;
    end
  end

  // job latch and read address counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      svc     <= service_time;
      n_last  <= last_index(server_count);
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
  end

  assign sts.last_issue = (rd_addr == n_last);

  // valid bits: cleared by reset and on a new case
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.start && new_case) begin
      vld <= '0;
    end else if (cmd.update) begin
      vld[best_idx] <= 1'b1;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[best_idx] <= t_new;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx <= rd_addr;
      rd_vld <= vld[rd_addr];
    end
  end

  // a never-written entry reads as zero
  assign v = rd_vld ? rd_data : '0;

  // running earliest / second earliest, lowest index wins on a tie
  always_ff @(posedge clk) begin
    if (rd_ok) begin
      if (rd_idx == '0) begin
        best       <= v;
        best_idx   <= rd_idx;
        has_second <= 1'b0;
      end else if (v < best) begin
        second     <= best;
        second_idx <= best_idx;
        has_second <= 1'b1;
        best       <= v;
        best_idx   <= rd_idx;
      end else if (!has_second || (v < second)) begin
        second     <= v;
        second_idx <= rd_idx;
        has_second <= 1'b1;
      end
    end
  end

  // saturating add and next-server choice
  assign sum   = {1'b0, best} + {{(TIME_W+1-SVC_W){1'b0}}, svc};
  assign t_new = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  always_comb begin
    priority if (!has_second) begin
      nxt_idx = best_idx;
    end else if ((t_new < second) || ((t_new == second) && (best_idx < second_idx))) begin
      nxt_idx = best_idx;
    end else begin
      nxt_idx = second_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_assigned <= NUM_W'(int'(best_idx) + 1);
      res_next     <= NUM_W'(int'(nxt_idx) + 1);
      res_sat      <= (t_new == TIME_MAX);
    end
  end

  // output register
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      assigned_server <= res_assigned;
      next_server     <= res_next;
      time_saturated  <= res_sat;
    end
  end

endmodule
